// ===== rtl/pfdvm_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM format decode / volume mixer package
// Shared widths, format and register codes, and the sample decode functions.
// ----------------------------------------------------------------------------
package pfdvm_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned VolW    = 8;
  localparam int unsigned FmtW    = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [FmtW-1:0] {
    FMT_S8     = 3'd0,
    FMT_U8     = 3'd1,
    FMT_S16BE  = 3'd2,
    FMT_S16LE  = 3'd3,
    FMT_U16BE  = 3'd4,
    FMT_U16LE  = 3'd5,
    FMT_MULAW  = 3'd6,
    FMT_NATIVE = 3'd7
  } fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOURCE_FORMAT   = 3'd0,
    CFG_SOUND_VOLUME    = 3'd1,
    CFG_TOP_PRIORITY    = 3'd2,
    CFG_SOUND_PRIORITY  = 3'd3,
    CFG_SEVERAL_PLAYING = 3'd4,
    CFG_MIN_VOLUME      = 3'd5
  } cfg_idx_e;

  localparam logic [VolW-1:0]    SoundVolumeRst = 8'd127;
  localparam logic [ByteW-1:0]   ByteSignFlip   = 8'h80;
  localparam logic [SampleW-1:0] WordSignFlip   = 16'h8000;
  localparam logic [SampleW-1:0] MulawBias      = 16'h0084;

  // G.711 mu-law expansion to 16-bit linear
  function automatic logic [SampleW-1:0] mulaw_decode(input logic [ByteW-1:0] b);
    logic [ByteW-1:0]    u;
    logic [SampleW-1:0]  mant;
    logic [SampleW-1:0]  t;
    u    = ~b;
    mant = {9'd0, u[3:0], 3'd0} + MulawBias;
    t    = mant << u[6:4];
    return u[7] ? (MulawBias - t) : (t - MulawBias);
  endfunction

  function automatic logic [SampleW-1:0] pcm_decode(input fmt_e fmt,
                                                    input logic [ByteW-1:0] lo_b,
                                                    input logic [ByteW-1:0] hi_b);
    logic [SampleW-1:0] be;
    logic [SampleW-1:0] le;
    logic [SampleW-1:0] res;
    be = {lo_b, hi_b};
    le = {hi_b, lo_b};
    case (fmt)
      FMT_S8:     res = {lo_b, 8'd0};
      FMT_U8:     res = {lo_b ^ ByteSignFlip, 8'd0};
      FMT_S16BE:  res = be;
      FMT_S16LE:  res = le;
      FMT_U16BE:  res = be ^ WordSignFlip;
      FMT_U16LE:  res = le ^ WordSignFlip;
      FMT_MULAW:  res = mulaw_decode(lo_b);
      FMT_NATIVE: res = le;
      default:    res = le;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/pfdvm_if.sv =====
// ----------------------------------------------------------------------------
// PCM format decode / volume mixer channel interfaces
// Valid/ready channels for sample input, mix result and register writes.
// ----------------------------------------------------------------------------
interface pfdvm_in_if import pfdvm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ByteW-1:0]          first_byte;
  logic [ByteW-1:0]          second_byte;
  logic                      channel_present;
  logic signed [SampleW-1:0] mix_in;

  modport source (output valid, first_byte, second_byte, channel_present, mix_in,
                  input ready);
  modport sink   (input valid, first_byte, second_byte, channel_present, mix_in,
                  output ready);
endinterface

interface pfdvm_out_if import pfdvm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] mix_out;
  logic signed [SampleW-1:0] decoded_sample;

  modport source (output valid, mix_out, decoded_sample, input ready);
  modport sink   (input valid, mix_out, decoded_sample, output ready);
endinterface

interface pfdvm_cfg_if import pfdvm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/pcm_format_decode_volume_mixer.sv =====
// ----------------------------------------------------------------------------
// PCM format decode / volume mixer
// Decodes one raw channel slot, scales it by the effective volume, adds to mix.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output side is ready and gives one
// result beat per input beat, from the result register. The beat is captured
// in an input register; decode, volume multiply (16x10 signed) and the 16-bit
// wrapping mix add sit between that register and the result register, so the
// throughput is one sample per cycle, limited only by output backpressure.
// Register writes are always accepted and must only be issued while idle.
// An absent channel reuses the last decoded sample (mono to stereo).
module pcm_format_decode_volume_mixer import pfdvm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfdvm_cfg_if.sink   cfg_i,
  pfdvm_in_if.sink    in_i,
  pfdvm_out_if.source out_o
);

  // configuration registers
  fmt_e             fmt_q;
  logic [VolW-1:0]  sound_vol_q;
  logic [VolW-1:0]  top_prio_q;
  logic [VolW-1:0]  sound_prio_q;
  logic             several_q;
  logic [VolW-1:0]  min_vol_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= FMT_S8;
      sound_vol_q  <= SoundVolumeRst;
      top_prio_q   <= '0;
      sound_prio_q <= '0;
      several_q    <= 1'b0;
      min_vol_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_SOURCE_FORMAT:   fmt_q        <= fmt_e'(cfg_i.data[FmtW-1:0]);
        CFG_SOUND_VOLUME:    sound_vol_q  <= cfg_i.data[VolW-1:0];
        CFG_TOP_PRIORITY:    top_prio_q   <= cfg_i.data[VolW-1:0];
        CFG_SOUND_PRIORITY:  sound_prio_q <= cfg_i.data[VolW-1:0];
        CFG_SEVERAL_PLAYING: several_q    <= cfg_i.data[0];
        CFG_MIN_VOLUME:      min_vol_q    <= cfg_i.data[VolW-1:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic                      s1_valid_q;
  logic [ByteW-1:0]          s1_lo_q, s1_hi_q;
  logic                      s1_present_q;
  logic signed [SampleW-1:0] s1_mix_q;

  // result register stage
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_mix_q, out_sample_q;

  logic [SampleW-1:0] held_q, held_d;
  logic               out_take, s1_fire, in_fire;

  assign out_take    = !out_valid_q || out_o.ready;
  assign s1_fire     = s1_valid_q && out_take;
  assign in_i.ready  = !s1_valid_q || out_take;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_lo_q      <= in_i.first_byte;
      s1_hi_q      <= in_i.second_byte;
      s1_present_q <= in_i.channel_present;
      s1_mix_q     <= in_i.mix_in;
    end
  end

  // effective volume: sound_volume - floor(gap/2), floored at min_volume, when top priority is nonzero and several play
  logic signed [VolW:0]   prio_gap;
  logic signed [VolW-1:0] half_gap;
  logic signed [VolW+2:0] vol_adj;
  logic [VolW:0]          vol;

  always_comb begin
    prio_gap = $signed({1'b0, top_prio_q}) - $signed({1'b0, sound_prio_q});
    half_gap = prio_gap[VolW:1];
    vol_adj  = $signed({3'b000, sound_vol_q}) - (VolW+3)'(half_gap);
    if (top_prio_q != '0 && several_q) begin
      if (vol_adj < $signed({3'b000, min_vol_q})) begin
        vol = {1'b0, min_vol_q};
      end else begin
        vol = vol_adj[VolW:0];
      end
    end else begin
      vol = {1'b0, sound_vol_q};
    end
  end

  // decode, scale, mix
  logic signed [SampleW+VolW+1:0] prod;
  logic signed [SampleW-1:0]      mix_d;

  always_comb begin
    held_d = s1_present_q ? pcm_decode(fmt_q, s1_lo_q, s1_hi_q) : held_q;
    prod   = $signed(held_d) * $signed({1'b0, vol});
    // only the low 16 bits of floor(prod / 128) reach the wrapped sum
    mix_d  = s1_mix_q + $signed(prod[SampleW+6:7]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        held_q <= held_d;
      end
      if (out_take) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_mix_q    <= mix_d;
      out_sample_q <= $signed(held_d);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.mix_out        = out_mix_q;
  assign out_o.decoded_sample = out_sample_q;

endmodule

// ===== rtl/pfdvm_checker.sv =====
// ----------------------------------------------------------------------------
// PCM format decode / volume mixer checker
// Port-level assertions on handshake behavior, bound to the top level.
// ----------------------------------------------------------------------------
module pfdvm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic cfg_ready_i
);

  // nothing comes out while in reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result beat during reset");

  // a ready output side never stalls the input side
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
                               out_ready_i |-> in_ready_i)
    else $error("input stalled with output ready");

  // an accepted beat passes the input register and reaches the output when the output side is ready
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
                              in_valid_i && in_ready_i ##1 out_ready_i |=> out_valid_i)
    else $error("accepted beat did not reach output");

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
                               out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped");

  // register writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("config port not ready");

endmodule

bind pcm_format_decode_volume_mixer pfdvm_checker u_pfdvm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cfg_ready_i (cfg_i.ready)
);

// ===== bench/pcm_format_decode_volume_mixer_tb.sv =====
// ----------------------------------------------------------------------------
// PCM format decode / volume mixer testbench
// Covers every source format, absent-channel reuse, the priority volume cut
// with its floor, floor rounding of the scale and mix wrap. A short table of
// directed beats runs first. Random phases follow, and each phase rewrites all
// registers. Result beats are checked in order against typed row values or an
// in-bench model of decode, volume and mix. Both sides add random idle bursts.
// ----------------------------------------------------------------------------
module pcm_format_decode_volume_mixer_tb;
  import pfdvm_pkg::*;

  localparam int CycleLimit   = 100000;
  localparam int DrainCycles  = 4;
  localparam int HoldCycles   = 150;
  localparam int NumPhases    = 9;
  localparam int BeatsPerPhase = 50;
  localparam int NumDirRows   = 26;

  typedef struct packed {
    logic [7:0]         first_byte;
    logic [7:0]         second_byte;
    logic               present;
    logic signed [15:0] mix_in;
  } slot_t;

  typedef struct packed {
    logic [15:0] mix_out;
    logic [15:0] decoded;
  } mix_res_t;

  typedef struct packed {
    fmt_e        fmt;
    logic [7:0]  vol;
    logic [7:0]  top_prio;
    logic [7:0]  snd_prio;
    logic        several;
    logic [7:0]  min_vol;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        present;
    logic [15:0] mix;
    logic        chk;
    logic [15:0] exp_mix;
    logic [15:0] exp_dec;
  } dir_row_t;

  // fmt, vol, top, own prio, several, min | bytes, present, mix | check, typed result
  localparam dir_row_t DirRows [NumDirRows] = '{
    // absent channel right after reset: held sample is zero
    '{FMT_S8,     8'd127, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h00, 8'h00, 1'b0, 16'h1234, 1'b1, 16'h1234, 16'h0000},
    '{FMT_S8,     8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h80, 8'h55, 1'b1, 16'h0000, 1'b1, 16'h8000, 16'h8000},
    '{FMT_S8,     8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h7f, 8'haa, 1'b1, 16'h0000, 1'b1, 16'h7f00, 16'h7f00},
    '{FMT_U8,     8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h00, 8'hff, 1'b1, 16'h0000, 1'b1, 16'h8000, 16'h8000},
    '{FMT_U8,     8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'hff, 8'h00, 1'b1, 16'h0000, 1'b1, 16'h7f00, 16'h7f00},
    '{FMT_S16BE,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h12, 8'h34, 1'b1, 16'h0000, 1'b1, 16'h1234, 16'h1234},
    '{FMT_S16LE,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h12, 8'h34, 1'b1, 16'h0000, 1'b1, 16'h3412, 16'h3412},
    '{FMT_U16BE,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h00, 8'h00, 1'b1, 16'h0000, 1'b1, 16'h8000, 16'h8000},
    '{FMT_U16LE,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'hff, 8'hff, 1'b1, 16'h0000, 1'b1, 16'h7fff, 16'h7fff},
    '{FMT_NATIVE, 8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h34, 8'h12, 1'b1, 16'h0000, 1'b1, 16'h1234, 16'h1234},
    '{FMT_MULAW,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'hff, 8'h00, 1'b1, 16'h0000, 1'b1, 16'h0000, 16'h0000},
    '{FMT_MULAW,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h00, 8'h00, 1'b1, 16'h0000, 1'b1, 16'h8284, 16'h8284},
    '{FMT_MULAW,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h80, 8'h5a, 1'b1, 16'h0000, 1'b1, 16'h7d7c, 16'h7d7c},
    // mono reuse: bytes ignored, previous sample repeats
    '{FMT_MULAW,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h00, 8'h00, 1'b0, 16'h0004, 1'b1, 16'h7d80, 16'h7d7c},
    '{FMT_MULAW,  8'd127, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h13, 8'h00, 1'b1, 16'h4321, 1'b0, 16'h0000, 16'h0000},
    // mix wraps, no saturation
    '{FMT_S16BE,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h7f, 8'hff, 1'b1, 16'h0001, 1'b1, 16'h8000, 16'h7fff},
    '{FMT_S16BE,  8'd128, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h80, 8'h00, 1'b1, 16'hffff, 1'b1, 16'h7fff, 16'h8000},
    '{FMT_S16BE,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0,
      8'h12, 8'h34, 1'b1, 16'h5555, 1'b1, 16'h5555, 16'h1234},
    '{FMT_S16BE,  8'd255, 8'd0,   8'd0,   1'b0, 8'd0,
      8'h80, 8'h00, 1'b1, 16'h0000, 1'b1, 16'h0100, 16'h8000},
    // -1 scaled rounds toward minus infinity
    '{FMT_S16BE,  8'd127, 8'd0,   8'd0,   1'b0, 8'd0,
      8'hff, 8'hff, 1'b1, 16'h0000, 1'b1, 16'hffff, 16'hffff},
    '{FMT_S16BE,  8'd100, 8'd60,  8'd20,  1'b1, 8'd0,
      8'h01, 8'h00, 1'b1, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    // own priority above top, odd gap: volume goes up
    '{FMT_S16BE,  8'd100, 8'd10,  8'd13,  1'b1, 8'd0,
      8'hc3, 8'h21, 1'b1, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{FMT_S16BE,  8'd10,  8'd200, 8'd0,   1'b1, 8'd50,
      8'h40, 8'h00, 1'b1, 16'h0000, 1'b0, 16'h0000, 16'h0000},
    '{FMT_S16BE,  8'd100, 8'd200, 8'd0,   1'b0, 8'd0,
      8'h40, 8'h00, 1'b1, 16'h7fff, 1'b0, 16'h0000, 16'h0000},
    '{FMT_S16BE,  8'd100, 8'd0,   8'd0,   1'b1, 8'd0,
      8'h40, 8'h00, 1'b1, 16'h8000, 1'b0, 16'h0000, 16'h0000},
    '{FMT_NATIVE, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255,
      8'hff, 8'h7f, 1'b1, 16'h8000, 1'b0, 16'h0000, 16'h0000}
  };

  logic clk;
  logic rst_n;

  pfdvm_cfg_if cfg_bus ();
  pfdvm_in_if  in_bus ();
  pfdvm_out_if out_bus ();

  pcm_format_decode_volume_mixer u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus.sink),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  // model state and register copies
  fmt_e        cur_fmt     = FMT_S8;
  logic [7:0]  cur_vol     = SoundVolumeRst;
  logic [7:0]  cur_top     = 8'd0;
  logic [7:0]  cur_sprio   = 8'd0;
  logic        cur_several = 1'b0;
  logic [7:0]  cur_minv    = 8'd0;
  logic [15:0] held_smp    = 16'h0000;

  mix_res_t pending_mix[$];
  int       err_cnt     = 0;
  int       cycle_cnt   = 0;
  bit       src_idle_on = 1'b1;
  bit       snk_idle_on = 1'b1;
  bit       hold_req    = 1'b0;
  int       hold_left   = 0;
  int       stall_left  = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("[pcm_format_decode_volume_mixer] ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] decode_slot(input fmt_e f, input logic [7:0] lo,
                                              input logic [7:0] hi);
    logic [7:0]  u;
    int          mag;
    logic [15:0] res;
    u   = ~lo;
    res = {hi, lo};
    case (f)
      FMT_S8:                res = {lo, 8'h00};
      FMT_U8:                res = {~lo[7], lo[6:0], 8'h00};
      FMT_S16BE:             res = {lo, hi};
      FMT_S16LE, FMT_NATIVE: res = {hi, lo};
      FMT_U16BE:             res = {~lo[7], lo[6:0], hi};
      FMT_U16LE:             res = {~hi[7], hi[6:0], lo};
      FMT_MULAW: begin
        // segment shift of biased mantissa, bias removed, sign from top bit
        mag = ((int'(u[3:0]) * 8 + 132) << u[6:4]) - 132;
        mag = u[7] ? -mag : mag;
        res = mag[15:0];
      end
      default:               res = {hi, lo};
    endcase
    return res;
  endfunction

  function automatic mix_res_t predict_mix(input slot_t s);
    int       vol;
    int       gap;
    int       scaled;
    mix_res_t r;
    if (s.present) held_smp = decode_slot(cur_fmt, s.first_byte, s.second_byte);
    vol = int'(cur_vol);
    if (cur_top != 8'd0 && cur_several) begin
      gap = int'(cur_top) - int'(cur_sprio);
      vol -= gap >>> 1;
      if (vol < int'(cur_minv)) vol = int'(cur_minv);
    end
    scaled    = (int'($signed(held_smp)) * vol) >>> 7;
    r.mix_out = s.mix_in + scaled[15:0];
    r.decoded = held_smp;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycle_cnt);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_mix.size() == 0) begin
        report_mismatch("unexpected beat", out_bus.mix_out, 16'h0000);
      end else begin
        if (out_bus.mix_out !== pending_mix[0].mix_out)
          report_mismatch("mix_out", out_bus.mix_out, pending_mix[0].mix_out);
        if (out_bus.decoded_sample !== pending_mix[0].decoded)
          report_mismatch("decoded_sample", out_bus.decoded_sample, pending_mix[0].decoded);
        void'(pending_mix.pop_front());
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_bus.ready = 1'b0;
        hold_left--;
      end else if (snk_idle_on && stall_left != 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else begin
        out_bus.ready = 1'b1;
        if (snk_idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [7:0] val);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_SOURCE_FORMAT:   cur_fmt     = fmt_e'(val[2:0]);
      CFG_SOUND_VOLUME:    cur_vol     = val;
      CFG_TOP_PRIORITY:    cur_top     = val;
      CFG_SOUND_PRIORITY:  cur_sprio   = val;
      CFG_SEVERAL_PLAYING: cur_several = val[0];
      CFG_MIN_VOLUME:      cur_minv    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic apply_settings(input fmt_e f, input logic [7:0] v, input logic [7:0] tp,
                                input logic [7:0] sp, input logic sev,
                                input logic [7:0] mv, input bit all);
    if (all || f != cur_fmt || v != cur_vol || tp != cur_top || sp != cur_sprio ||
        sev != cur_several || mv != cur_minv)
      wait_idle();
    if (all || f != cur_fmt)       cfg_write(CFG_SOURCE_FORMAT, {5'd0, f});
    if (all || v != cur_vol)       cfg_write(CFG_SOUND_VOLUME, v);
    if (all || tp != cur_top)      cfg_write(CFG_TOP_PRIORITY, tp);
    if (all || sp != cur_sprio)    cfg_write(CFG_SOUND_PRIORITY, sp);
    if (all || sev != cur_several) cfg_write(CFG_SEVERAL_PLAYING, {7'd0, sev});
    if (all || mv != cur_minv)     cfg_write(CFG_MIN_VOLUME, mv);
  endtask

  // typed expectation replaces the model's one when given; model still runs
  task automatic send_slot(input slot_t s, input bit chk, input mix_res_t want);
    mix_res_t pred;
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_bus.valid           = 1'b1;
    in_bus.first_byte      = s.first_byte;
    in_bus.second_byte     = s.second_byte;
    in_bus.channel_present = s.present;
    in_bus.mix_in          = s.mix_in;
    do @(posedge clk); while (!in_bus.ready);
    pred = predict_mix(s);
    pending_mix.push_back(chk ? want : pred);
  endtask

  function automatic slot_t rand_slot();
    slot_t s;
    s.first_byte  = 8'($urandom);
    s.second_byte = 8'($urandom);
    s.present     = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 15))
      0:       s.mix_in = 16'h7fff;
      1:       s.mix_in = 16'h8000;
      2:       s.mix_in = 16'hffff;
      default: s.mix_in = 16'($urandom);
    endcase
    return s;
  endfunction

  initial begin
    fmt_e       ph_fmt;
    logic [7:0] ph_vol;
    logic [7:0] ph_top;
    logic [7:0] ph_sprio;
    logic       ph_sev;
    logic [7:0] ph_minv;
    dir_row_t   row;

    rst_n                  = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = CFG_SOURCE_FORMAT;
    cfg_bus.data           = 8'd0;
    in_bus.valid           = 1'b0;
    in_bus.first_byte      = 8'd0;
    in_bus.second_byte     = 8'd0;
    in_bus.channel_present = 1'b0;
    in_bus.mix_in          = 16'sd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NumDirRows; i++) begin
      row = DirRows[i];
      apply_settings(row.fmt, row.vol, row.top_prio, row.snd_prio, row.several,
                     row.min_vol, 1'b0);
      send_slot('{row.b0, row.b1, row.present, row.mix}, row.chk,
                '{row.exp_mix, row.exp_dec});
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          ph_fmt = FMT_S8;     ph_vol = 8'd0;   ph_top  = 8'd0;
          ph_sprio = 8'd0;     ph_sev = 1'b0;   ph_minv = 8'd0;
        end
        1: begin
          ph_fmt = FMT_NATIVE; ph_vol = 8'd255; ph_top  = 8'd255;
          ph_sprio = 8'd255;   ph_sev = 1'b1;   ph_minv = 8'd255;
        end
        default: begin
          ph_fmt   = fmt_e'(3'(p - 1));
          ph_vol   = 8'($urandom);
          ph_top   = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
          ph_sprio = 8'($urandom);
          ph_sev   = ($urandom_range(0, 3) != 0);
          ph_minv  = 8'($urandom_range(0, 96));
        end
      endcase
      apply_settings(ph_fmt, ph_vol, ph_top, ph_sprio, ph_sev, ph_minv, 1'b1);

      src_idle_on = (p != 4) && (p != NumPhases - 1);
      snk_idle_on = (p != NumPhases - 1);
      // long output hold-off while input keeps coming: pipeline backs up
      if (p == 4) hold_req = 1'b1;

      for (int k = 0; k < BeatsPerPhase; k++) send_slot(rand_slot(), 1'b0, '0);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[pcm_format_decode_volume_mixer] OK");
    end else begin
      $display("[pcm_format_decode_volume_mixer] ERROR");
    end
    $finish;
  end

endmodule

// ===== pcm_format_decode_volume_mixer.f =====
rtl/pfdvm_pkg.sv
rtl/pfdvm_if.sv
rtl/pcm_format_decode_volume_mixer.sv
rtl/pfdvm_checker.sv
bench/pcm_format_decode_volume_mixer_tb.sv
